// ===== hdl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent and consequent in the same cycle
`define AES_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes assertion failed");

// consequent in the cycle after the antecedent
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes assertion failed");

`endif

// ===== hdl/aes_pkg.sv =====
package aes_pkg;

    // one input transaction
    typedef struct packed {
        logic        func;
        logic [63:0] block_high;
        logic [63:0] block_low;
        logic        first_block;
    } in_t;

    // one result transaction
    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_t;

    // key schedule status toward the round engine
    typedef struct packed {
        logic       done;
        logic [3:0] rounds;
    } kx_stat_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIZE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAINING   = 3'd5;

    // key size codes
    localparam logic [1:0] KS_192 = 2'd1;
    localparam logic [1:0] KS_256 = 2'd2;

    localparam logic [7:0] POLY = 8'h1b;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

    // mix column coefficients, forward and inverse
    localparam logic [3:0] MIX_FWD [4] = '{4'd2, 4'd3, 4'd1, 4'd1};
    localparam logic [3:0] MIX_INV [4] = '{4'd14, 4'd11, 4'd13, 4'd9};

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? POLY : 8'h00);
    endfunction

    // multiply by a coefficient below 16
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
                r = r ^ p;
            p = xtime(p);
        end
        return r;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte i of the state sits in bits 127-8i down
    function automatic logic [127:0] sub_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int i = 0; i < 16; i++)
            t[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        return t;
    endfunction

    function automatic logic [127:0] shift_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
                t[127-8*(c*4+r) -: 8] = s[127-8*(src*4+r) -: 8];
            end
        return t;
    endfunction

    function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        logic [7:0]   v;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                v = 8'h00;
                for (int k = 0; k < 4; k++)
                    v = v ^ gmul(s[127-8*(c*4+k) -: 8],
                                 inv ? MIX_INV[(k + 4 - r) % 4] : MIX_FWD[(k + 4 - r) % 4]);
                t[127-8*(c*4+r) -: 8] = v;
            end
        return t;
    endfunction

endpackage

// ===== hdl/aes_front.sv =====
module aes_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  aes_pkg::in_t  in_data,
    output logic          q_valid,
    output aes_pkg::in_t  q_data,
    input  logic          q_pop
);
    import aes_pkg::*;

    in_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    // two-entry queue between intake and round engine
    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ===== hdl/aes_keyexp.sv =====
module aes_keyexp #(
    parameter int ROUND_KEY_WORDS = 60,
    localparam int ROWS = ROUND_KEY_WORDS / 4,
    localparam int AW = $clog2(ROWS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [255:0]      key,
    input  logic [1:0]        key_size,
    input  logic [AW-1:0]     rd_addr,
    output logic [127:0]      rd_data,
    output aes_pkg::kx_stat_t stat
);
    import aes_pkg::*;

    localparam int JW = $clog2(ROUND_KEY_WORDS);

    logic [127:0] mem [ROWS];
    logic [127:0] rd_data_reg;

    logic          busy_reg;
    logic          done_reg;
    logic [JW-1:0] j_reg;
    logic [JW:0]   total_reg;
    logic [2:0]    mod_reg;
    logic [3:0]    rc_reg;
    logic [3:0]    nk_reg;
    logic [3:0]    rounds_reg;
    logic [31:0]   win_reg [8];
    logic [31:0]   rb_reg [3];
    logic [31:0]   kword [8];

    logic [3:0]    nr_sel;
    logic [31:0]   t_word;
    logic [31:0]   far_word;
    logic [31:0]   new_word;
    logic          last_word;

    // key bytes as 32-bit words, word 0 first
    always_comb
    begin
        for (int i = 0; i < 8; i++)
            kword[i] = key[255-32*i -: 32];
    end

    // round count for the chosen key size, falling back when the store is short
    always_comb
    begin
        if (key_size == KS_192)
            nr_sel = 4'd12;
        else if (key_size == KS_256)
            nr_sel = 4'd14;
        else
            nr_sel = 4'd10;
        if (4 * (int'(nr_sel) + 1) > ROUND_KEY_WORDS)
            nr_sel = 4'd10;
    end

    // next schedule word
    always_comb
    begin
        if (mod_reg == 3'd0)
            t_word = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon(rc_reg), 24'h0};
        else if (nk_reg == 4'd8 && mod_reg == 3'd4)
            t_word = sub_word(win_reg[0]);
        else
            t_word = win_reg[0];
        far_word  = win_reg[nk_reg[2:0] - 3'd1];
        new_word  = (j_reg < JW'(nk_reg)) ? kword[j_reg[2:0]] : (far_word ^ t_word);
        last_word = ({1'b0, j_reg} == total_reg - (JW+1)'(1));
    end

    // schedule sequencer, one word per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            j_reg      <= '0;
            total_reg  <= '0;
            mod_reg    <= 3'd0;
            rc_reg     <= 4'd0;
            nk_reg     <= 4'd4;
            rounds_reg <= 4'd10;
        end
        else
        begin
            done_reg <= busy_reg && last_word;
            if (start)
            begin
                busy_reg   <= 1'b1;
                j_reg      <= '0;
                mod_reg    <= 3'd0;
                rc_reg     <= 4'd0;
                rounds_reg <= nr_sel;
                nk_reg     <= nr_sel - 4'd6;
                total_reg  <= (JW+1)'({nr_sel + 4'd1, 2'b00});
            end
            else if (busy_reg)
            begin
                j_reg <= j_reg + JW'(1);
                if (mod_reg == nk_reg[2:0] - 3'd1)
                begin
                    mod_reg <= 3'd0;
                    rc_reg  <= rc_reg + 4'd1;
                end
                else
                    mod_reg <= mod_reg + 3'd1;
                if (last_word)
                    busy_reg <= 1'b0;
            end
        end
    end

    // sliding window of recent words and row assembly
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            win_reg[0] <= new_word;
            for (int i = 1; i < 8; i++)
                win_reg[i] <= win_reg[i-1];
            rb_reg[0] <= new_word;
            rb_reg[1] <= rb_reg[0];
            rb_reg[2] <= rb_reg[1];
        end
    end

    // round key store, one 128-bit row per round
    always_ff @(posedge clk)
    begin
        if (busy_reg && j_reg[1:0] == 2'd3)
            mem[AW'(j_reg >> 2)] <= {rb_reg[2], rb_reg[1], rb_reg[0], new_word};
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data     = rd_data_reg;
    assign stat.done   = done_reg;
    assign stat.rounds = rounds_reg;

endmodule

// ===== hdl/aes_rounds.sv =====
module aes_rounds #(
    parameter int ROUND_KEY_WORDS = 60,
    localparam int AW = $clog2(ROUND_KEY_WORDS / 4)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  aes_pkg::in_t      q_data,
    output logic              q_pop,
    input  logic              chaining,
    input  logic              stale,
    output logic              kx_start,
    input  aes_pkg::kx_stat_t kx_stat,
    output logic [AW-1:0]     rk_addr,
    input  logic [127:0]      rk_data,
    output logic              out_valid,
    input  logic              out_stall,
    output aes_pkg::out_t     out_data
);
    import aes_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXPAND = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_FIRST  = 6'b001000,
        ST_ROUND  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t       state_reg, state_next;
    logic [127:0] blk_reg, blk_next;
    logic [127:0] cv_reg, cv_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] st_reg, st_next;
    logic         dec_reg, dec_next;
    logic         cbc_reg, cbc_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         out_valid_reg, out_valid_next;
    out_t         out_reg, out_next;

    logic [127:0] enc_sh;
    logic [127:0] enc_res;
    logic [127:0] dec_add;
    logic [127:0] dec_res;
    logic [127:0] fin;
    logic         last_rnd;

    // one round in each direction
    always_comb
    begin
        enc_sh   = shift_state(sub_state(st_reg, 1'b0), 1'b0);
        enc_res  = ((rnd_reg == kx_stat.rounds) ? enc_sh : mix_state(enc_sh, 1'b0)) ^ rk_data;
        dec_add  = sub_state(shift_state(st_reg, 1'b1), 1'b1) ^ rk_data;
        dec_res  = (rnd_reg == 4'd0) ? dec_add : mix_state(dec_add, 1'b1);
        last_rnd = dec_reg ? (rnd_reg == 4'd0) : (rnd_reg == kx_stat.rounds);
        fin      = dec_reg ? (st_reg ^ cv_reg) : st_reg;
    end

    // sequencer for one block
    always_comb
    begin
        state_next     = state_reg;
        blk_next       = blk_reg;
        cv_next        = cv_reg;
        chain_next     = chain_reg;
        st_next        = st_reg;
        dec_next       = dec_reg;
        cbc_next       = cbc_reg;
        rnd_next       = rnd_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        kx_start       = 1'b0;
        rk_addr        = AW'(rnd_reg);

        // result taken downstream
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    blk_next = {q_data.block_high, q_data.block_low};
                    dec_next = q_data.func;
                    cbc_next = chaining;
                    cv_next  = (chaining && !q_data.first_block) ? chain_reg : '0;
                    if (q_data.first_block)
                        chain_next = '0;
                    if (stale)
                    begin
                        kx_start   = 1'b1;
                        state_next = ST_EXPAND;
                    end
                    else
                        state_next = ST_LOAD;
                end
            end
            ST_EXPAND:
            begin
                if (kx_stat.done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                rnd_next   = dec_reg ? kx_stat.rounds : 4'd0;
                rk_addr    = AW'(rnd_next);
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                st_next    = blk_reg ^ (dec_reg ? '0 : cv_reg) ^ rk_data;
                rnd_next   = dec_reg ? (kx_stat.rounds - 4'd1) : 4'd1;
                rk_addr    = AW'(rnd_next);
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                st_next = dec_reg ? dec_res : enc_res;
                if (last_rnd)
                    state_next = ST_FINISH;
                else
                begin
                    rnd_next = dec_reg ? (rnd_reg - 4'd1) : (rnd_reg + 4'd1);
                    rk_addr  = AW'(rnd_next);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.result_high = fin[127:64];
                    out_next.result_low  = fin[63:0];
                    out_valid_next       = 1'b1;
                    if (cbc_reg)
                        chain_next = dec_reg ? blk_reg : st_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
            rnd_reg       <= 4'd0;
            dec_reg       <= 1'b0;
            cbc_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
            rnd_reg       <= rnd_next;
            dec_reg       <= dec_next;
            cbc_reg       <= cbc_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        cv_reg  <= cv_next;
        st_reg  <= st_next;
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hdl/aes_block_cipher_ecb_cbc.sv =====
// AES-128/192/256 block engine, ECB or CBC with a zero initialization vector.
// Configuration: write key words 0..3, key_size and chaining over the cfg channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data) while no block is in flight.
// Input: in_valid/in_stall with in_data (func, block, first_block); a block is
// taken when in_valid is high and in_stall is low. A two-entry queue sits in front.
// Output: out_valid/out_stall with out_data; the result holds while out_stall is
// high, and the engine can finish the next block into its own state meanwhile.
// Sequence: the round engine passes IDLE, LOAD, FIRST, one ROUND state per round
// (10, 12 or 14 rounds) and FINISH for each block, one round per cycle against one
// round-key row read per cycle. A new block leaves the queue only after FINISH.
// The first block after reset or after a key or key_size write first runs the
// key schedule, one word per cycle for 4 * (Nr + 1) words.
// Reset clears the queue, the output valid, the chain value and the config registers;
// the round-key store is rebuilt from the all-zero 128-bit key on the first block.
module aes_block_cipher_ecb_cbc #(
    parameter int ROUND_KEY_WORDS = 60
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  aes_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output aes_pkg::out_t                 out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import aes_pkg::*;

    localparam int AW = $clog2(ROUND_KEY_WORDS / 4);

    logic [63:0]   key_reg [4];
    logic [1:0]    key_size_reg;
    logic          chaining_reg;
    logic          stale_reg;
    logic          cfg_wr;

    logic          q_valid;
    in_t           q_data;
    logic          q_pop;
    logic          kx_start;
    kx_stat_t      kx_stat;
    logic [AW-1:0] rk_addr;
    logic [127:0]  rk_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration registers and schedule-stale flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                key_reg[i] <= '0;
            key_size_reg <= 2'd0;
            chaining_reg <= 1'b0;
            stale_reg    <= 1'b1;
        end
        else
        begin
            if (kx_start)
                stale_reg <= 1'b0;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3:
                    begin
                        key_reg[cfg_index[1:0]] <= cfg_data;
                        stale_reg               <= 1'b1;
                    end
                    CFG_KEY_SIZE:
                    begin
                        key_size_reg <= cfg_data[1:0];
                        stale_reg    <= 1'b1;
                    end
                    CFG_CHAINING:
                    begin
                        chaining_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    aes_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    aes_keyexp #(
        .ROUND_KEY_WORDS (ROUND_KEY_WORDS)
    ) u_keyexp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (kx_start),
        .key      ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .key_size (key_size_reg),
        .rd_addr  (rk_addr),
        .rd_data  (rk_data),
        .stat     (kx_stat)
    );

    aes_rounds #(
        .ROUND_KEY_WORDS (ROUND_KEY_WORDS)
    ) u_rounds (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .chaining  (chaining_reg),
        .stale     (stale_reg),
        .kx_start  (kx_start),
        .kx_stat   (kx_stat),
        .rk_addr   (rk_addr),
        .rk_data   (rk_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/aes_checker.sv =====
`include "assert_macros.svh"

module aes_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input aes_pkg::in_t                  in_data,
    input logic                          out_valid,
    input logic                          out_stall,
    input aes_pkg::out_t                 out_data,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [aes_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [63:0]                   cfg_data
);

    // a stalled result stays offered
    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // a stalled result keeps its value
    `AES_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

    // the queue only fills up on an accepted transaction
    `AES_ASSERT_SAME(a_stall_rise, clk, rst_n, $rose(in_stall), $past(in_valid && !in_stall))

    // configuration is always taken
    `AES_ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind aes_block_cipher_ecb_cbc aes_checker u_aes_checker (.*);
